// ----- hw/rtl/srrc_pkg.sv -----
// shared types, constants and the control program of the step rate ramp controller
// no dependencies; used by the channel interfaces, the divider and the top level
`default_nettype none

package srrc_pkg;

  // field widths
  localparam int REQ_W    = 2;
  localparam int MODE_W   = 2;
  localparam int SPEED_W  = 16;
  localparam int ACCEL_W  = 15;
  localparam int POS_W    = 32;
  localparam int TIMER_W  = 16;
  localparam int WIDE_W   = 18;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_TOP_LIMIT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_BOTTOM_LIMIT = 2'd3;

  // register reset values
  localparam logic [ACCEL_W-1:0] MAX_ACCEL_RST = 15'd0;
  localparam logic [ACCEL_W-1:0] MAX_SPEED_RST = 15'd4000;
  localparam logic signed [POS_W-1:0] Z_TOP_RST    = 32'sd10;
  localparam logic signed [POS_W-1:0] Z_BOTTOM_RST = 32'sd0;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ENABLE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DISABLE = 2'd2;

  // run modes
  localparam logic [MODE_W-1:0] MODE_DISABLED  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENABLED   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISABLING = 2'd2;

  // step clock and period limit
  localparam int DIV_W      = WIDE_W;
  localparam int DIVISOR_W  = ACCEL_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam logic [DIV_W-1:0]   STEP_CLOCK = 18'd250000;
  localparam logic [TIMER_W-1:0] PERIOD_MAX = 16'hFFFF;

  // divider status seen by the sequencer
  typedef struct packed {
    logic             busy;
    logic [DIV_W-1:0] quotient;
  } div_stat_t;

  // micro operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_MODE     = 4'd0;
  localparam logic [OP_W-1:0] OP_CLIP     = 4'd1;
  localparam logic [OP_W-1:0] OP_CLAMP    = 4'd2;
  localparam logic [OP_W-1:0] OP_DIVSTART = 4'd3;
  localparam logic [OP_W-1:0] OP_DIVWAIT  = 4'd4;
  localparam logic [OP_W-1:0] OP_PERIOD   = 4'd5;
  localparam logic [OP_W-1:0] OP_ELAPSED  = 4'd6;
  localparam logic [OP_W-1:0] OP_REST     = 4'd7;
  localparam logic [OP_W-1:0] OP_LOAD     = 4'd8;
  localparam logic [OP_W-1:0] OP_DONE     = 4'd9;

  // sequencing conditions
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] C_NEXT    = 3'd0;
  localparam logic [COND_W-1:0] C_NOCHG   = 3'd1;
  localparam logic [COND_W-1:0] C_FZERO   = 3'd2;
  localparam logic [COND_W-1:0] C_DIVBUSY = 3'd3;
  localparam logic [COND_W-1:0] C_OUTHOLD = 3'd4;

  // program addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_MODE     = 4'd0;
  localparam logic [PC_W-1:0] PC_CLIP     = 4'd1;
  localparam logic [PC_W-1:0] PC_CLAMP    = 4'd2;
  localparam logic [PC_W-1:0] PC_DIVSTART = 4'd3;
  localparam logic [PC_W-1:0] PC_DIVWAIT  = 4'd4;
  localparam logic [PC_W-1:0] PC_PERIOD   = 4'd5;
  localparam logic [PC_W-1:0] PC_ELAPSED  = 4'd6;
  localparam logic [PC_W-1:0] PC_REST     = 4'd7;
  localparam logic [PC_W-1:0] PC_LOAD     = 4'd8;
  localparam logic [PC_W-1:0] PC_DONE     = 4'd9;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ucode_t;

  // control program, one word per step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      PC_MODE:     w = '{op: OP_MODE,     cond: C_NEXT,    target: PC_CLIP};
      PC_CLIP:     w = '{op: OP_CLIP,     cond: C_NOCHG,   target: PC_DONE};
      PC_CLAMP:    w = '{op: OP_CLAMP,    cond: C_NEXT,    target: PC_DIVSTART};
      PC_DIVSTART: w = '{op: OP_DIVSTART, cond: C_FZERO,   target: PC_PERIOD};
      PC_DIVWAIT:  w = '{op: OP_DIVWAIT,  cond: C_DIVBUSY, target: PC_DIVWAIT};
      PC_PERIOD:   w = '{op: OP_PERIOD,   cond: C_NEXT,    target: PC_ELAPSED};
      PC_ELAPSED:  w = '{op: OP_ELAPSED,  cond: C_NEXT,    target: PC_REST};
      PC_REST:     w = '{op: OP_REST,     cond: C_NEXT,    target: PC_LOAD};
      PC_LOAD:     w = '{op: OP_LOAD,     cond: C_NEXT,    target: PC_DONE};
      default:     w = '{op: OP_DONE,     cond: C_OUTHOLD, target: PC_MODE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/srrc_if.sv -----
// request and result channels of the step rate ramp controller
// depends on srrc_pkg for field widths
`default_nettype none

interface srrc_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic [srrc_pkg::REQ_W-1:0]             req_type;
  logic signed [srrc_pkg::SPEED_W-1:0]    target_speed;
  logic signed [srrc_pkg::POS_W-1:0]      z_position;
  logic [srrc_pkg::TIMER_W-1:0]           timer_count;
  logic                                   counting_up;

  modport source (output valid, req_type, target_speed, z_position, timer_count,
                  counting_up, input ready);
  modport sink (input valid, req_type, target_speed, z_position, timer_count,
                counting_up, output ready);
endinterface

interface srrc_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic [srrc_pkg::MODE_W-1:0]            mode;
  logic signed [srrc_pkg::SPEED_W-1:0]    speed_now;
  logic                                   step_direction;
  logic [srrc_pkg::TIMER_W-1:0]           step_period;
  logic [srrc_pkg::TIMER_W-1:0]           counter_load;
  logic                                   timer_write;
  logic                                   handoff;
  logic                                   overrun;

  modport source (output valid, mode, speed_now, step_direction, step_period,
                  counter_load, timer_write, handoff, overrun, input ready);
  modport sink (input valid, mode, speed_now, step_direction, step_period,
                counter_load, timer_write, handoff, overrun, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/step_rate_ramp_controller.sv -----
// step rate ramp controller: a tick whose speed changes runs every step of the program
// from transfer to result register, the bit-serial period divider included; a tick to
// zero speed skips the divider, and a request or a tick at target speed ends after the
// clip step. One item is in work at a time. The result register lets the next item start
// while a result waits. Synchronous reset clears mode, speed, direction, last period and
// the configuration registers to their defaults; no clearing pass.
`default_nettype none

module step_rate_ramp_controller (
  input  logic                              clk,
  input  logic                              rst,
  srrc_cmd_if.sink                          cmd,
  srrc_rsp_if.source                        rsp,
  input  logic                              wr_en,
  input  logic [srrc_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [srrc_pkg::CFG_DATA_W-1:0]   wr_data
);

  localparam int W  = srrc_pkg::WIDE_W;
  localparam int SW = srrc_pkg::SPEED_W;
  localparam int TW = srrc_pkg::TIMER_W;

  // configuration registers
  logic [srrc_pkg::ACCEL_W-1:0]      max_accel;
  logic [srrc_pkg::ACCEL_W-1:0]      max_speed;
  logic signed [srrc_pkg::POS_W-1:0] z_top_limit;
  logic signed [srrc_pkg::POS_W-1:0] z_bottom_limit;

  // sequencer
  logic                        busy;
  logic [srrc_pkg::PC_W-1:0]   pc;
  logic [srrc_pkg::PC_W-1:0]   pc_next;
  logic                        finish;
  srrc_pkg::ucode_t            uc;
  logic                        accept;
  logic                        out_free;

  // captured item
  logic [srrc_pkg::REQ_W-1:0]        req;
  logic signed [SW-1:0]              target;
  logic signed [srrc_pkg::POS_W-1:0] zpos;
  logic [TW-1:0]                     tcount;
  logic                              up;

  // block state
  logic [srrc_pkg::MODE_W-1:0]  mode;
  logic signed [SW-1:0]         speed;
  logic                         dir;
  logic [TW-1:0]                last_period;

  // datapath registers
  logic signed [W-1:0]            delta;
  logic                           chg;
  logic signed [W-1:0]            sum;
  logic [srrc_pkg::ACCEL_W-1:0]   freq;
  logic [TW-1:0]                  period;
  logic [TW-1:0]                  elapsed;
  logic [TW-1:0]                  rest;
  logic [TW-1:0]                  load;
  logic                           twrite;
  logic                           handoff;
  logic                           overrun;

  // result register
  logic                         rsp_valid;
  logic [srrc_pkg::MODE_W-1:0]  rsp_mode;
  logic signed [SW-1:0]         rsp_speed;
  logic                         rsp_dir;
  logic [TW-1:0]                rsp_period;
  logic [TW-1:0]                rsp_load;
  logic                         rsp_twrite;
  logic                         rsp_handoff;
  logic                         rsp_overrun;

  // datapath logic
  logic signed [W-1:0]            tgt_wide;
  logic signed [W-1:0]            speed_wide;
  logic signed [W-1:0]            delta_calc;
  logic signed [W-1:0]            accel_wide;
  logic signed [W-1:0]            clipped;
  logic signed [W-1:0]            sum_calc;
  logic signed [W-1:0]            mspd_wide;
  logic signed [W-1:0]            clamped;
  logic signed [W-1:0]            clamped_neg;
  logic [srrc_pkg::ACCEL_W-1:0]   freq_calc;
  logic [TW-1:0]                  period_calc;
  logic [TW-1:0]                  elapsed_calc;
  logic [TW-1:0]                  rest_calc;
  logic [TW-1:0]                  load_calc;
  logic                           z_out;

  srrc_pkg::div_stat_t div_stat;
  logic                div_start;

  assign uc       = srrc_pkg::ucode_rom(pc);
  assign accept   = cmd.valid && !busy;
  assign out_free = !rsp_valid || rsp.ready;
  assign cmd.ready = !busy;

  // period divider
  assign div_start = busy && (uc.op == srrc_pkg::OP_DIVSTART) && (freq != '0);

  srrc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (srrc_pkg::STEP_CLOCK),
    .divisor  (freq),
    .stat     (div_stat)
  );

  // next step of the program
  always_comb begin
    pc_next = pc + 1'b1;
    finish  = 1'b0;
    unique case (uc.cond)
      srrc_pkg::C_NOCHG: begin
        if (!chg) pc_next = uc.target;
      end
      srrc_pkg::C_FZERO: begin
        if (freq == '0) pc_next = uc.target;
      end
      srrc_pkg::C_DIVBUSY: begin
        if (div_stat.busy) pc_next = pc;
      end
      srrc_pkg::C_OUTHOLD: begin
        if (out_free) begin
          finish  = 1'b1;
          pc_next = uc.target;
        end else begin
          pc_next = pc;
        end
      end
      default: ;
    endcase
  end

  // speed target, delta and overrun check
  always_comb begin
    speed_wide = {{(W-SW){speed[SW-1]}}, speed};
    tgt_wide   = (mode == srrc_pkg::MODE_ENABLED) ? {{(W-SW){target[SW-1]}}, target} : '0;
    delta_calc = tgt_wide - speed_wide;
    z_out      = (zpos > z_top_limit) || (zpos < z_bottom_limit);
  end

  // acceleration clip and speed clamp
  always_comb begin
    accel_wide = {{(W-srrc_pkg::ACCEL_W){1'b0}}, max_accel};
    if (delta > accel_wide) begin
      clipped = accel_wide;
    end else if (delta < -accel_wide) begin
      clipped = -accel_wide;
    end else begin
      clipped = delta;
    end
    sum_calc  = speed_wide + clipped;
    mspd_wide = {{(W-srrc_pkg::ACCEL_W){1'b0}}, max_speed};
    if (sum > mspd_wide) begin
      clamped = mspd_wide;
    end else if (sum < -mspd_wide) begin
      clamped = -mspd_wide;
    end else begin
      clamped = sum;
    end
    clamped_neg = -clamped;
    freq_calc   = clamped[W-1] ? clamped_neg[srrc_pkg::ACCEL_W-1:0]
                               : clamped[srrc_pkg::ACCEL_W-1:0];
  end

  // period and phase preserving reload
  always_comb begin
    if (freq == '0) begin
      period_calc = srrc_pkg::PERIOD_MAX;
    end else if (div_stat.quotient > {{(W-TW){1'b0}}, srrc_pkg::PERIOD_MAX}) begin
      period_calc = srrc_pkg::PERIOD_MAX;
    end else begin
      period_calc = div_stat.quotient[TW-1:0];
    end
    elapsed_calc = up ? tcount : last_period - tcount;
    rest_calc    = (elapsed > period) ? '0 : period - elapsed;
    load_calc    = up ? period - rest : rest;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_accel      <= srrc_pkg::MAX_ACCEL_RST;
      max_speed      <= srrc_pkg::MAX_SPEED_RST;
      z_top_limit    <= srrc_pkg::Z_TOP_RST;
      z_bottom_limit <= srrc_pkg::Z_BOTTOM_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        srrc_pkg::CFG_MAX_ACCEL:   max_accel      <= wr_data[srrc_pkg::ACCEL_W-1:0];
        srrc_pkg::CFG_MAX_SPEED:   max_speed      <= wr_data[srrc_pkg::ACCEL_W-1:0];
        srrc_pkg::CFG_Z_TOP_LIMIT: z_top_limit    <= wr_data[srrc_pkg::POS_W-1:0];
        default:                   z_bottom_limit <= wr_data[srrc_pkg::POS_W-1:0];
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= srrc_pkg::PC_MODE;
    end else if (!busy) begin
      if (accept) begin
        busy <= 1'b1;
        pc   <= srrc_pkg::PC_MODE;
      end
    end else begin
      pc <= pc_next;
      if (finish) busy <= 1'b0;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req    <= cmd.req_type;
      target <= cmd.target_speed;
      zpos   <= cmd.z_position;
      tcount <= cmd.timer_count;
      up     <= cmd.counting_up;
    end
  end

  // block state updated by the program
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= srrc_pkg::MODE_DISABLED;
      speed       <= '0;
      dir         <= 1'b1;
      last_period <= srrc_pkg::PERIOD_MAX;
    end else if (busy) begin
      case (uc.op)
        srrc_pkg::OP_MODE: begin
          case (req)
            srrc_pkg::REQ_ENABLE: mode <= srrc_pkg::MODE_ENABLED;
            srrc_pkg::REQ_DISABLE: begin
              if (mode == srrc_pkg::MODE_ENABLED) mode <= srrc_pkg::MODE_DISABLING;
            end
            srrc_pkg::REQ_TICK: begin
              if (mode == srrc_pkg::MODE_DISABLING && speed == '0) begin
                mode <= srrc_pkg::MODE_DISABLED;
              end
            end
            default: ;
          endcase
        end
        srrc_pkg::OP_CLAMP: begin
          speed <= clamped[SW-1:0];
          dir   <= !clamped[W-1];
        end
        srrc_pkg::OP_LOAD: last_period <= period;
        default: ;
      endcase
    end
  end

  // working registers of one item
  always_ff @(posedge clk) begin
    if (accept) begin
      twrite  <= 1'b0;
      load    <= '0;
      handoff <= 1'b0;
      overrun <= 1'b0;
    end else if (busy) begin
      case (uc.op)
        srrc_pkg::OP_MODE: begin
          delta   <= delta_calc;
          chg     <= (req == srrc_pkg::REQ_TICK) && (delta_calc != '0);
          handoff <= (req == srrc_pkg::REQ_TICK) && (mode == srrc_pkg::MODE_DISABLING)
                     && (speed == '0);
          overrun <= (req == srrc_pkg::REQ_TICK) && (mode == srrc_pkg::MODE_ENABLED) && z_out;
        end
        srrc_pkg::OP_CLIP:    sum     <= sum_calc;
        srrc_pkg::OP_CLAMP:   freq    <= freq_calc;
        srrc_pkg::OP_PERIOD:  period  <= period_calc;
        srrc_pkg::OP_ELAPSED: elapsed <= elapsed_calc;
        srrc_pkg::OP_REST:    rest    <= rest_calc;
        srrc_pkg::OP_LOAD: begin
          load   <= load_calc;
          twrite <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (busy && finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && finish) begin
      rsp_mode    <= mode;
      rsp_speed   <= speed;
      rsp_dir     <= dir;
      rsp_period  <= last_period;
      rsp_load    <= load;
      rsp_twrite  <= twrite;
      rsp_handoff <= handoff;
      rsp_overrun <= overrun;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.mode           = rsp_mode;
  assign rsp.speed_now      = rsp_speed;
  assign rsp.step_direction = rsp_dir;
  assign rsp.step_period    = rsp_period;
  assign rsp.counter_load   = rsp_load;
  assign rsp.timer_write    = rsp_twrite;
  assign rsp.handoff        = rsp_handoff;
  assign rsp.overrun        = rsp_overrun;

endmodule

`default_nettype wire

// ----- hw/rtl/srrc_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on srrc_pkg for widths and the status struct
`default_nettype none

module srrc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [srrc_pkg::DIV_W-1:0]       dividend,
  input  logic [srrc_pkg::DIVISOR_W-1:0]   divisor,
  output srrc_pkg::div_stat_t              stat
);

  logic                              busy;
  logic [srrc_pkg::DIV_CNT_W-1:0]    cnt;
  logic [srrc_pkg::DIV_W-1:0]        quo;
  logic [srrc_pkg::DIVISOR_W-1:0]    rem;
  logic [srrc_pkg::DIVISOR_W:0]      rem_shift;
  logic [srrc_pkg::DIVISOR_W:0]      rem_sub;
  logic                              fits;

  // shift in the next dividend bit and trial subtract
  always_comb begin
    rem_shift = {rem, quo[srrc_pkg::DIV_W-1]};
    fits      = rem_shift >= {1'b0, divisor};
    rem_sub   = rem_shift - {1'b0, divisor};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= srrc_pkg::DIV_CNT_W'(srrc_pkg::DIV_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // quotient and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[srrc_pkg::DIV_W-2:0], fits};
      rem <= fits ? rem_sub[srrc_pkg::DIVISOR_W-1:0] : rem_shift[srrc_pkg::DIVISOR_W-1:0];
    end
  end

  assign stat.busy     = busy;
  assign stat.quotient = quo;

endmodule

`default_nettype wire

// ----- hw/rtl/srrc_checker.sv -----
// port level checks of the step rate ramp controller result channel
// depends on srrc_pkg; bound to step_rate_ramp_controller
`default_nettype none

module srrc_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                rsp_valid,
  input wire logic                                rsp_ready,
  input wire logic [srrc_pkg::MODE_W-1:0]         rsp_mode,
  input wire logic signed [srrc_pkg::SPEED_W-1:0] rsp_speed_now,
  input wire logic                                rsp_step_direction,
  input wire logic [srrc_pkg::TIMER_W-1:0]        rsp_step_period,
  input wire logic [srrc_pkg::TIMER_W-1:0]        rsp_counter_load,
  input wire logic                                rsp_timer_write,
  input wire logic                                rsp_handoff,
  input wire logic                                rsp_overrun
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_mode, rsp_speed_now,
      rsp_step_direction, rsp_step_period, rsp_counter_load, rsp_timer_write,
      rsp_handoff, rsp_overrun}))
    else $error("stalled result changed");

  // handoff only from a stopped motor with no timer update
  a_handoff: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_handoff |-> rsp_mode == srrc_pkg::MODE_DISABLED
      && rsp_speed_now == '0 && !rsp_timer_write)
    else $error("handoff without stop");

  // overrun is only flagged while enabled
  a_overrun: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_overrun |-> rsp_mode == srrc_pkg::MODE_ENABLED)
    else $error("overrun outside enabled mode");

  // zero speed means stopped timer and positive direction
  a_stopped: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_speed_now == '0 |-> rsp_step_period == srrc_pkg::PERIOD_MAX
      && rsp_step_direction)
    else $error("zero speed with running period");

endmodule

bind step_rate_ramp_controller srrc_checker u_srrc_checker (
  .clk                (clk),
  .rst                (rst),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_mode           (rsp.mode),
  .rsp_speed_now      (rsp.speed_now),
  .rsp_step_direction (rsp.step_direction),
  .rsp_step_period    (rsp.step_period),
  .rsp_counter_load   (rsp.counter_load),
  .rsp_timer_write    (rsp.timer_write),
  .rsp_handoff        (rsp.handoff),
  .rsp_overrun        (rsp.overrun)
);

`default_nettype wire

// ----- test/tb_step_rate_ramp_controller.sv -----
// testbench for the step rate ramp controller: directed requests and ramp extremes, then
// random ramp sequences under several register settings, checked against an inline predictor
// depends on srrc_pkg, srrc_cmd_if / srrc_rsp_if and the step_rate_ramp_controller rtl
`timescale 1ns / 100ps

module tb_step_rate_ramp_controller;

  // unused request code, must behave as a plain request
  localparam logic [srrc_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int PHASE_ITEMS   = 165;
  localparam int STREAM_ITEMS  = 200;

  typedef struct packed {
    logic [srrc_pkg::REQ_W-1:0]          req_type;
    logic signed [srrc_pkg::SPEED_W-1:0] target_speed;
    logic signed [srrc_pkg::POS_W-1:0]   z_position;
    logic [srrc_pkg::TIMER_W-1:0]        timer_count;
    logic                                counting_up;
  } ramp_req_t;

  typedef struct packed {
    logic [srrc_pkg::MODE_W-1:0]         mode;
    logic signed [srrc_pkg::SPEED_W-1:0] speed_now;
    logic                                step_direction;
    logic [srrc_pkg::TIMER_W-1:0]        step_period;
    logic [srrc_pkg::TIMER_W-1:0]        counter_load;
    logic                                timer_write;
    logic                                handoff;
    logic                                overrun;
  } ramp_res_t;

  // register settings visited by the random ramps
  typedef enum {
    SET_FULL_SCALE,
    SET_UNIT,
    SET_SLOW_RAMP,
    SET_NO_ACCEL,
    SET_ZERO_SPEED,
    SET_CROSSED_LIMITS
  } ramp_setup_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en;
  logic [srrc_pkg::CFG_IDX_W-1:0] wr_index;
  logic [srrc_pkg::CFG_DATA_W-1:0] wr_data;

  srrc_cmd_if cmd_ch ();
  srrc_rsp_if rsp_ch ();

  step_rate_ramp_controller i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch),
    .rsp      (rsp_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted controller state and register copies
  logic [srrc_pkg::MODE_W-1:0]  ramp_mode     = srrc_pkg::MODE_DISABLED;
  int                           ramp_speed    = 0;
  logic                         ramp_dir      = 1'b1;
  int                           ramp_period   = int'(srrc_pkg::PERIOD_MAX);
  logic [srrc_pkg::ACCEL_W-1:0] cfg_accel     = srrc_pkg::MAX_ACCEL_RST;
  logic [srrc_pkg::ACCEL_W-1:0] cfg_speed_lim = srrc_pkg::MAX_SPEED_RST;
  logic signed [srrc_pkg::POS_W-1:0] cfg_z_top    = srrc_pkg::Z_TOP_RST;
  logic signed [srrc_pkg::POS_W-1:0] cfg_z_bottom = srrc_pkg::Z_BOTTOM_RST;

  ramp_res_t expected_results[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int src_idle_pct = 20;
  int sink_idle_pct = 20;

  // advance the predicted state by one request and return the expected result
  function automatic ramp_res_t ramp_predict(ramp_req_t r);
    ramp_res_t res;
    int tgt, delta, nxt, freq, period, elapsed, rest, accel_lim, speed_lim;
    res = '0;
    tgt = $signed(r.target_speed);
    case (r.req_type)
      srrc_pkg::REQ_ENABLE: begin
        ramp_mode = srrc_pkg::MODE_ENABLED;
      end
      srrc_pkg::REQ_DISABLE: begin
        if (ramp_mode == srrc_pkg::MODE_ENABLED) ramp_mode = srrc_pkg::MODE_DISABLING;
      end
      srrc_pkg::REQ_TICK: begin
        if (ramp_mode != srrc_pkg::MODE_ENABLED) begin
          tgt = 0;
          if (ramp_mode == srrc_pkg::MODE_DISABLING && ramp_speed == 0) begin
            ramp_mode = srrc_pkg::MODE_DISABLED;
            res.handoff = 1'b1;
          end
        end else if ($signed(r.z_position) > cfg_z_top ||
                     $signed(r.z_position) < cfg_z_bottom) begin
          res.overrun = 1'b1;
        end
        delta = tgt - ramp_speed;
        if (delta != 0) begin
          accel_lim = int'(cfg_accel);
          speed_lim = int'(cfg_speed_lim);
          if (delta > accel_lim) delta = accel_lim;
          else if (delta < -accel_lim) delta = -accel_lim;
          // sum taken wide, then clamped
          nxt = ramp_speed + delta;
          if (nxt > speed_lim) nxt = speed_lim;
          else if (nxt < -speed_lim) nxt = -speed_lim;
          ramp_speed = nxt;
          ramp_dir = (nxt >= 0);
          freq = (nxt < 0) ? -nxt : nxt;
          if (freq == 0) begin
            period = int'(srrc_pkg::PERIOD_MAX);
          end else begin
            period = int'(srrc_pkg::STEP_CLOCK) / freq;
            if (period > int'(srrc_pkg::PERIOD_MAX)) period = int'(srrc_pkg::PERIOD_MAX);
          end
          // keep the step phase already elapsed
          elapsed = r.counting_up ? int'(r.timer_count)
                                  : ((ramp_period - int'(r.timer_count)) & 16'hFFFF);
          rest = (elapsed > period) ? 0 : period - elapsed;
          nxt = r.counting_up ? period - rest : rest;
          res.counter_load = nxt[15:0];
          ramp_period = period;
          res.timer_write = 1'b1;
        end
      end
      default: ;
    endcase
    res.mode = ramp_mode;
    res.speed_now = ramp_speed[15:0];
    res.step_direction = ramp_dir;
    res.step_period = ramp_period[15:0];
    return res;
  endfunction

  function automatic ramp_req_t make_req(logic [srrc_pkg::REQ_W-1:0] req, int tgt, int zpos,
                                         int tcount, logic up);
    ramp_req_t r;
    r.req_type = req;
    r.target_speed = tgt[15:0];
    r.z_position = zpos;
    r.timer_count = tcount[15:0];
    r.counting_up = up;
    return r;
  endfunction

  // random request, weighted toward ticks, with targets near interesting points
  function automatic ramp_req_t random_item();
    ramp_req_t r;
    int pick, tgt;
    pick = $urandom_range(0, 99);
    if (ramp_mode == srrc_pkg::MODE_DISABLED && pick < 25) r.req_type = srrc_pkg::REQ_ENABLE;
    else if (pick < 84) r.req_type = srrc_pkg::REQ_TICK;
    else if (pick < 91) r.req_type = srrc_pkg::REQ_DISABLE;
    else if (pick < 95) r.req_type = srrc_pkg::REQ_ENABLE;
    else r.req_type = REQ_UNUSED;
    case ($urandom_range(0, 5))
      0: tgt = $urandom;
      1: tgt = int'($urandom_range(0, 400)) - 200;
      2: tgt = 0;
      3: tgt = ramp_speed + int'($urandom_range(0, 6)) - 3;
      4: tgt = $urandom_range(0, 1) ? 32767 : -32768;
      default: tgt = int'($urandom_range(0, 8000)) - 4000;
    endcase
    r.target_speed = tgt[15:0];
    case ($urandom_range(0, 3))
      0: r.z_position = $urandom;
      1: r.z_position = cfg_z_top + int'($urandom_range(0, 4)) - 2;
      2: r.z_position = cfg_z_bottom + int'($urandom_range(0, 4)) - 2;
      default: r.z_position = (cfg_z_top >>> 1) + (cfg_z_bottom >>> 1);
    endcase
    if ($urandom_range(0, 1)) r.timer_count = srrc_pkg::TIMER_W'($urandom);
    else r.timer_count = srrc_pkg::TIMER_W'($urandom_range(0, ramp_period));
    r.counting_up = 1'($urandom);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // send one request, entered and left at a falling edge; valid drops after the transfer
  task automatic send_item(ramp_req_t r);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      cmd_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    cmd_ch.req_type = r.req_type;
    cmd_ch.target_speed = r.target_speed;
    cmd_ch.z_position = r.z_position;
    cmd_ch.timer_count = r.timer_count;
    cmd_ch.counting_up = r.counting_up;
    cmd_ch.valid = 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    expected_results.push_back(ramp_predict(r));
    @(negedge clk);
    cmd_ch.valid = 1'b0;
  endtask

  // wait until every expected result has come back
  task automatic wait_drained();
    cmd_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [srrc_pkg::CFG_IDX_W-1:0] idx,
                           logic [srrc_pkg::CFG_DATA_W-1:0] data);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = data;
    @(negedge clk);
    wr_en = 1'b0;
    case (idx)
      srrc_pkg::CFG_MAX_ACCEL:   cfg_accel = data[srrc_pkg::ACCEL_W-1:0];
      srrc_pkg::CFG_MAX_SPEED:   cfg_speed_lim = data[srrc_pkg::ACCEL_W-1:0];
      srrc_pkg::CFG_Z_TOP_LIMIT: cfg_z_top = data;
      default:                   cfg_z_bottom = data;
    endcase
  endtask

  // idle the block, then load all four registers; junk above bit 14 on the narrow ones
  task automatic apply_limits(int accel, int speed_lim, int top, int bottom);
    wait_drained();
    cfg_write(srrc_pkg::CFG_MAX_ACCEL, ($urandom & 32'hFFFF_8000) | accel);
    cfg_write(srrc_pkg::CFG_MAX_SPEED, ($urandom & 32'hFFFF_8000) | speed_lim);
    cfg_write(srrc_pkg::CFG_Z_TOP_LIMIT, top);
    cfg_write(srrc_pkg::CFG_Z_BOTTOM_LIMIT, bottom);
  endtask

  task automatic test_requests_and_extremes();
    // reset settings: zero accel, so an enabled tick cannot move the speed
    send_item(make_req(srrc_pkg::REQ_TICK, 0, 0, 0, 1'b1));
    send_item(make_req(REQ_UNUSED, 1234, 0, 16'h5555, 1'b0));
    send_item(make_req(srrc_pkg::REQ_DISABLE, 0, 0, 0, 1'b0));
    send_item(make_req(srrc_pkg::REQ_ENABLE, 0, 5, 0, 1'b1));
    send_item(make_req(srrc_pkg::REQ_TICK, 1000, 5, 16'h00FF, 1'b1));
    send_item(make_req(srrc_pkg::REQ_TICK, 0, 11, 0, 1'b1));
    apply_limits(32767, 32767, 100, -100);
    // full scale both ways, overrun on both sides, capped periods
    send_item(make_req(srrc_pkg::REQ_TICK, 32767, 101, 16'hFFFF, 1'b1));
    send_item(make_req(srrc_pkg::REQ_TICK, -32768, -101, 16'h0000, 1'b0));
    send_item(make_req(srrc_pkg::REQ_TICK, 1, 32'h7FFF_FFFF, 16'h1234, 1'b1));
    send_item(make_req(srrc_pkg::REQ_TICK, 3, 32'h8000_0000, 16'hFFFF, 1'b0));
    send_item(make_req(srrc_pkg::REQ_TICK, 4, 100, 16'h8000, 1'b0));
    send_item(make_req(srrc_pkg::REQ_TICK, 4, -100, 16'h0001, 1'b1));
    // disable ramps to zero, then hands off
    send_item(make_req(srrc_pkg::REQ_DISABLE, 0, 0, 0, 1'b1));
    send_item(make_req(srrc_pkg::REQ_TICK, 5000, 0, 16'h0010, 1'b1));
    send_item(make_req(srrc_pkg::REQ_TICK, 5000, 0, 0, 1'b0));
    send_item(make_req(srrc_pkg::REQ_ENABLE, 0, 0, 0, 1'b0));
    send_item(make_req(srrc_pkg::REQ_TICK, 20000, 0, 16'h0003, 1'b1));
    // lowered speed limit takes effect only when the speed changes
    wait_drained();
    cfg_write(srrc_pkg::CFG_MAX_SPEED, 100);
    send_item(make_req(srrc_pkg::REQ_TICK, 20000, 0, 16'h0002, 1'b0));
    send_item(make_req(srrc_pkg::REQ_TICK, 19999, 0, 16'h0002, 1'b0));
    // zero speed limit forces the speed to zero
    wait_drained();
    cfg_write(srrc_pkg::CFG_MAX_SPEED, 0);
    send_item(make_req(srrc_pkg::REQ_TICK, 50, 0, 16'h0007, 1'b1));
  endtask

  task automatic test_random_ramps();
    ramp_setup_t setup;
    int n;
    for (int k = 0; k < 6; k++) begin
      setup = ramp_setup_t'(k);
      case (setup)
        SET_FULL_SCALE: apply_limits(32767, 32767, 32'h7FFF_FFFF, 32'h8000_0000);
        SET_UNIT:       apply_limits(1, 1, $urandom, $urandom);
        SET_SLOW_RAMP:  apply_limits($urandom_range(1, 600), $urandom_range(1, 32767),
                                     $urandom_range(0, 1000), -$urandom_range(0, 1000));
        SET_NO_ACCEL:   apply_limits(0, $urandom_range(100, 32767), $urandom, $urandom);
        SET_ZERO_SPEED: apply_limits($urandom_range(1, 32767), 0, 0, 0);
        default:        apply_limits($urandom_range(1, 32767), $urandom_range(1, 32767),
                                     -$urandom_range(0, 1000), $urandom_range(1, 1000));
      endcase
      // stall mix changes per setting, some with none on one side
      src_idle_pct = (k % 3) * 20;
      sink_idle_pct = ((k + 1) % 3) * 20;
      for (n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
    end
  endtask

  task automatic test_back_to_back();
    int n;
    apply_limits($urandom_range(1, 2000), $urandom_range(1, 32767),
                 $urandom_range(0, 50000), -$urandom_range(0, 50000));
    src_idle_pct = 0;
    sink_idle_pct = 0;
    send_item(make_req(srrc_pkg::REQ_ENABLE, 0, 0, 0, 1'b1));
    for (n = 0; n < STREAM_ITEMS; n++) send_item(random_item());
  endtask

  // result sink ready, stalled in bursts
  initial begin
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    ramp_res_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual mode %0h speed %0h",
                 $time, rsp_ch.mode, rsp_ch.speed_now);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("mode", want.mode, rsp_ch.mode);
        check_field("speed_now", want.speed_now, rsp_ch.speed_now);
        check_field("step_direction", want.step_direction, rsp_ch.step_direction);
        check_field("step_period", want.step_period, rsp_ch.step_period);
        check_field("counter_load", want.counter_load, rsp_ch.counter_load);
        check_field("timer_write", want.timer_write, rsp_ch.timer_write);
        check_field("handoff", want.handoff, rsp_ch.handoff);
        check_field("overrun", want.overrun, rsp_ch.overrun);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.req_type = srrc_pkg::REQ_TICK;
    cmd_ch.target_speed = '0;
    cmd_ch.z_position = '0;
    cmd_ch.timer_count = '0;
    cmd_ch.counting_up = 1'b0;
    wr_en = 1'b0;
    wr_index = srrc_pkg::CFG_MAX_ACCEL;
    wr_data = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;
    test_requests_and_extremes();
    test_random_ramps();
    test_back_to_back();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- step_rate_ramp_controller.f -----
hw/rtl/srrc_pkg.sv
hw/rtl/srrc_if.sv
hw/rtl/srrc_div.sv
hw/rtl/step_rate_ramp_controller.sv
hw/rtl/srrc_checker.sv
test/tb_step_rate_ramp_controller.sv
